// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define VSPC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset
`define VSPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- src/vspc_pkg.sv -----
`timescale 1ns / 1ps

package vspc_pkg;

	// Field widths
	localparam int CAPTURE_BITS = 16;
	localparam int WIDTH_BITS   = 17;
	localparam int LINE_BITS    = 9;
	localparam int COUNT8_BITS  = 8;
	localparam int TOTAL_BITS   = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	// Timer width default
	localparam int TIMER_BITS_DEFAULT = 16;

	// Fixed width windows, inclusive
	localparam logic [WIDTH_BITS-1:0] VS_LO = 17'd55;
	localparam logic [WIDTH_BITS-1:0] VS_HI = 17'd80;
	localparam logic [WIDTH_BITS-1:0] HL_LO = 17'd670;
	localparam logic [WIDTH_BITS-1:0] HL_HI = 17'd710;

	// Half-line counts that mark the field parity
	localparam logic [COUNT8_BITS-1:0] HALF_ODD  = 8'd4;
	localparam logic [COUNT8_BITS-1:0] HALF_EVEN = 8'd5;

	// Register reset values
	localparam logic [15:0]          RST_TIMER_RELOAD = 16'd65535;
	localparam logic [LINE_BITS-1:0] RST_LINES_FIELD  = 9'd305;
	localparam logic [7:0]           RST_VSYNC_ARM    = 8'd6;
	localparam logic [15:0]          RST_LINE_MIN     = 16'd1478;
	localparam logic [15:0]          RST_LINE_MAX     = 16'd1488;

	// Pulse classes
	typedef enum logic [1:0] {
		CLS_NONE  = 2'd0,
		CLS_VSYNC = 2'd1,
		CLS_LINE  = 2'd2,
		CLS_HALF  = 2'd3
	} pulse_class_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_TIMER_RELOAD    = 3'd0,
		CFG_LINES_PER_FIELD = 3'd1,
		CFG_VSYNC_ARM_COUNT = 3'd2,
		CFG_LINE_MIN        = 3'd3,
		CFG_LINE_MAX        = 3'd4
	} cfg_idx_t;

endpackage

// ----- src/video_sync_pulse_classifier.sv -----
`timescale 1ns / 1ps
// Video sync pulse classifier.
// Input channel (in_valid/in_ready, capture_value): one capture timer value per
// detected sync edge. Output channel (out_valid/out_ready): one result per input,
// with the interval since the previous edge, its class, the line count, field end
// and parity flags and the saturating odd/even field totals.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready; writes
// are expected only while no item is in flight.
// The transfer loads the input register, and the item then moves into the result
// register, where out_valid rises. Throughput: one item per cycle while the receiver
// does not stall; the whole per-edge update is one subtract, a few window compares and
// counter increments in a single stage.
// A stalled receiver holds the result register; the input register still takes
// one more item, after which in_ready drops until the result is taken.
// Reset clears all tracking state, arms half-line detection and loads the register
// defaults (reload 65535, 305 lines, arm count 6, line window 1478..1488).
// TIMER_BITS below 16 keeps only the low timer bits of captures and reload.
module video_sync_pulse_classifier #(
	parameter int TIMER_BITS = vspc_pkg::TIMER_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [vspc_pkg::CAPTURE_BITS-1:0]   capture_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [vspc_pkg::WIDTH_BITS-1:0]     pulse_width,
	output logic [1:0]                          pulse_class,
	output logic [vspc_pkg::LINE_BITS-1:0]      line_number,
	output logic                                field_end,
	output logic                                field_odd,
	output logic [vspc_pkg::TOTAL_BITS-1:0]     odd_changes,
	output logic [vspc_pkg::TOTAL_BITS-1:0]     even_changes,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vspc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [vspc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int CAP_BITS = (TIMER_BITS < vspc_pkg::CAPTURE_BITS) ?
		TIMER_BITS : vspc_pkg::CAPTURE_BITS;
	localparam int WB = vspc_pkg::WIDTH_BITS;
	localparam int LB = vspc_pkg::LINE_BITS;
	localparam int CB = vspc_pkg::COUNT8_BITS;
	localparam int TB = vspc_pkg::TOTAL_BITS;

	localparam logic [LB-1:0] LINE_TOP  = {LB{1'b1}};
	localparam logic [CB-1:0] COUNT_TOP = {CB{1'b1}};
	localparam logic [TB-1:0] TOTAL_TOP = {TB{1'b1}};

	// Configuration registers
	logic [15:0]   timer_reload_q;
	logic [LB-1:0] lines_per_field_q;
	logic [7:0]    vsync_arm_count_q;
	logic [15:0]   line_min_q;
	logic [15:0]   line_max_q;

	// Tracking state
	logic [CAP_BITS-1:0] prev_capture_q;
	logic [CB-1:0]       vsync_count_q;
	logic [LB-1:0]       line_count_q;
	logic [CB-1:0]       half_count_q;
	logic                line_armed_q;
	logic                half_armed_q;
	logic                parity_q;
	logic [TB-1:0]       odd_total_q;
	logic [TB-1:0]       even_total_q;

	// Input stage
	logic                             valid_s1;
	logic [vspc_pkg::CAPTURE_BITS-1:0] capture_s1;

	// Result register
	logic          out_valid_q;
	logic [WB-1:0] width_q;
	logic [1:0]    class_q;
	logic          fend_q;

	logic advance;

	// Next-state values
	logic [CAP_BITS-1:0] cur;
	logic [CAP_BITS-1:0] reload;
	logic [WB-1:0]       width;
	logic                vs_hit, line_hit, half_hit;
	logic [CB-1:0]       vsync_n, half_n;
	logic [LB-1:0]       line_n;
	logic                line_armed_n, half_armed_n, parity_n, fend_n;
	logic [TB-1:0]       odd_n, even_n;
	vspc_pkg::pulse_class_t cls_n;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_reload_q    <= vspc_pkg::RST_TIMER_RELOAD;
			lines_per_field_q <= vspc_pkg::RST_LINES_FIELD;
			vsync_arm_count_q <= vspc_pkg::RST_VSYNC_ARM;
			line_min_q        <= vspc_pkg::RST_LINE_MIN;
			line_max_q        <= vspc_pkg::RST_LINE_MAX;
		end else if (cfg_valid && cfg_ready) begin
			unique case (vspc_pkg::cfg_idx_t'(cfg_index))
				vspc_pkg::CFG_TIMER_RELOAD:    timer_reload_q    <= cfg_data;
				vspc_pkg::CFG_LINES_PER_FIELD: lines_per_field_q <= cfg_data[LB-1:0];
				vspc_pkg::CFG_VSYNC_ARM_COUNT: vsync_arm_count_q <= cfg_data[7:0];
				vspc_pkg::CFG_LINE_MIN:        line_min_q        <= cfg_data;
				vspc_pkg::CFG_LINE_MAX:        line_max_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			capture_s1 <= capture_value;
		end
	end

	// Interval with wrap at reload plus one
	always_comb begin
		cur    = capture_s1[CAP_BITS-1:0];
		reload = timer_reload_q[CAP_BITS-1:0];
		if (cur >= prev_capture_q) begin
			width = WB'(cur) - WB'(prev_capture_q);
		end else begin
			width = WB'(cur) + WB'(reload) + WB'(1) - WB'(prev_capture_q);
		end
	end

	// Classification and counter update, checks in order vsync, line, half
	always_comb begin
		vsync_n      = vsync_count_q;
		line_n       = line_count_q;
		half_n       = half_count_q;
		line_armed_n = line_armed_q;
		half_armed_n = half_armed_q;
		parity_n     = parity_q;
		odd_n        = odd_total_q;
		even_n       = even_total_q;
		fend_n       = 1'b0;
		cls_n        = vspc_pkg::CLS_NONE;

		vs_hit = (width >= vspc_pkg::VS_LO) && (width <= vspc_pkg::VS_HI);
		if (vs_hit) begin
			vsync_n      = (vsync_n != COUNT_TOP) ? vsync_n + CB'(1) : COUNT_TOP;
			line_armed_n = 1'b1;
			if (vsync_n >= vsync_arm_count_q) begin
				half_armed_n = 1'b1;
			end
			cls_n = vspc_pkg::CLS_VSYNC;
		end

		line_hit = (width >= WB'(line_min_q)) && (width <= WB'(line_max_q)) && line_armed_n;
		if (line_hit) begin
			line_n       = (line_n != LINE_TOP) ? line_n + LB'(1) : LINE_TOP;
			half_n       = '0;
			half_armed_n = 1'b0;
			if (line_n == lines_per_field_q) begin
				line_armed_n = 1'b0;
				line_n       = '0;
				vsync_n      = '0;
				fend_n       = 1'b1;
			end
			if (cls_n == vspc_pkg::CLS_NONE) begin
				cls_n = vspc_pkg::CLS_LINE;
			end
		end

		half_hit = (width >= vspc_pkg::HL_LO) && (width <= vspc_pkg::HL_HI) && half_armed_n;
		if (half_hit) begin
			half_n = (half_n != COUNT_TOP) ? half_n + CB'(1) : COUNT_TOP;
			if (half_n == vspc_pkg::HALF_ODD) begin
				parity_n = 1'b1;
				odd_n    = (odd_n != TOTAL_TOP) ? odd_n + TB'(1) : TOTAL_TOP;
			end else if (half_n == vspc_pkg::HALF_EVEN) begin
				parity_n = 1'b0;
				even_n   = (even_n != TOTAL_TOP) ? even_n + TB'(1) : TOTAL_TOP;
			end
			if (cls_n == vspc_pkg::CLS_NONE) begin
				cls_n = vspc_pkg::CLS_HALF;
			end
		end
	end

	// Tracking state, updated as each item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_capture_q <= '0;
			vsync_count_q  <= '0;
			line_count_q   <= '0;
			half_count_q   <= '0;
			line_armed_q   <= 1'b0;
			half_armed_q   <= 1'b1;
			parity_q       <= 1'b0;
			odd_total_q    <= '0;
			even_total_q   <= '0;
		end else if (advance) begin
			prev_capture_q <= cur;
			vsync_count_q  <= vsync_n;
			line_count_q   <= line_n;
			half_count_q   <= half_n;
			line_armed_q   <= line_armed_n;
			half_armed_q   <= half_armed_n;
			parity_q       <= parity_n;
			odd_total_q    <= odd_n;
			even_total_q   <= even_n;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			width_q <= width;
			class_q <= cls_n;
			fend_q  <= fend_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign pulse_width  = width_q;
	assign pulse_class  = class_q;
	assign line_number  = line_count_q;
	assign field_end    = fend_q;
	assign field_odd    = parity_q;
	assign odd_changes  = odd_total_q;
	assign even_changes = even_total_q;

endmodule

// ----- src/vspc_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vspc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [vspc_pkg::WIDTH_BITS-1:0] pulse_width,
	input logic [1:0]                      pulse_class,
	input logic [vspc_pkg::LINE_BITS-1:0]  line_number,
	input logic                            field_end
);

	// A stalled result holds its interval
	`VSPC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(pulse_width))

	// Field end leaves the line count cleared
	`VSPC_ASSERT_IMPL(a_fend_clears, out_valid && field_end, line_number == '0)

	// Vertical sync class only inside its window
	`VSPC_ASSERT_IMPL(a_vsync_window, out_valid && pulse_class == vspc_pkg::CLS_VSYNC, pulse_width >= vspc_pkg::VS_LO && pulse_width <= vspc_pkg::VS_HI)

	// Field end only comes from a line period transfer
	`VSPC_ASSERT_IMPL(a_fend_line, out_valid && field_end, pulse_class == vspc_pkg::CLS_LINE || pulse_class == vspc_pkg::CLS_VSYNC)

endmodule

bind video_sync_pulse_classifier vspc_checker u_vspc_checker (.*);
